// ----- rtl/core/prma_pkg.sv -----
`default_nettype none

package prma_pkg;

    // field widths
    localparam int CH_W      = 2;
    localparam int COUNT_W   = 32;
    localparam int RATE_W    = 16;
    localparam int TOTAL_W   = 22;
    localparam int WIN_W     = 7;

    // configuration registers: one window length per channel slot
    localparam int NUM_REGS  = 4;
    localparam int REG_IDX_W = 2;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = 2;

    // divider step counter, counts TOTAL_W steps
    localparam int DIV_CNT_W = 5;

    // one classified sample handed from front to back
    typedef struct packed {
        logic              absent;
        logic [CH_W-1:0]   channel;
        logic [RATE_W-1:0] rate;
    } work_t;

    // configuration write as seen by the back end
    typedef struct packed {
        logic                 we;
        logic [REG_IDX_W-1:0] index;
        logic [WIN_W-1:0]     data;
    } cfg_wr_t;

    // queue status
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_CALC,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/prma_in_if.sv -----
`default_nettype none

interface prma_in_if;
    import prma_pkg::*;

    logic               valid;
    logic               ready;
    logic [CH_W-1:0]    channel;
    logic [COUNT_W-1:0] pulse_count;

    modport source (output valid, channel, pulse_count, input ready);
    modport sink   (input valid, channel, pulse_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/prma_out_if.sv -----
`default_nettype none

interface prma_out_if;
    import prma_pkg::*;

    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   out_channel;
    logic [RATE_W-1:0] period_rate;
    logic [RATE_W-1:0] average_rate;

    modport source (output valid, out_channel, period_rate, average_rate, input ready);
    modport sink   (input valid, out_channel, period_rate, average_rate, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/prma_front.sv -----
`default_nettype none

module prma_front #(
    parameter int CHANNELS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    prma_in_if.sink               in_ch,
    input  prma_pkg::queue_stat_t q_stat,
    output logic                  push,
    output prma_pkg::work_t       push_word
);
    import prma_pkg::*;

    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [COUNT_W-1:0] last_count_reg [CHANNELS];
    logic [CIW-1:0]     ch_idx;
    logic               absent;
    logic [COUNT_W-1:0] diff;

    // accept whenever the queue has room
    assign in_ch.ready = !q_stat.full;
    assign push        = in_ch.valid && in_ch.ready;

    // classify and compute the period rate
    assign absent = (32'(in_ch.channel) >= CHANNELS);
    assign ch_idx = CIW'(in_ch.channel);
    assign diff   = in_ch.pulse_count - last_count_reg[ch_idx];

    assign push_word.absent  = absent;
    assign push_word.channel = in_ch.channel;
    assign push_word.rate    = absent ? '0 : diff[RATE_W-1:0];

    // last cumulative count per channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                last_count_reg[i] <= '0;
            end
        end
        else if (push && !absent)
        begin
            last_count_reg[ch_idx] <= in_ch.pulse_count;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/prma_queue.sv -----
`default_nettype none

module prma_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  prma_pkg::work_t       push_word,
    input  logic                  pop,
    output prma_pkg::work_t       head,
    output prma_pkg::queue_stat_t q_stat
);
    import prma_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    work_t             entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign head         = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/prma_div.sv -----
`default_nettype none

module prma_div #(
    parameter int DVS_W = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [prma_pkg::TOTAL_W-1:0] dividend,
    input  logic [DVS_W-1:0]             divisor,
    output logic                         done,
    output logic [prma_pkg::TOTAL_W-1:0] quotient
);
    import prma_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TOTAL_W-1:0]   dq_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0]       rem_sh;
    logic                 fits;
    logic [DVS_W:0]       rem_new;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign rem_sh  = {rem_reg, dq_reg[TOTAL_W-1]};
    assign fits    = (rem_sh >= {1'b0, dvs_reg});
    assign rem_new = fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;

    assign done     = done_reg;
    assign quotient = dq_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(TOTAL_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                end
            end
        end
    end

    // datapath: dividend shifts out while quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[TOTAL_W-2:0], fits};
            rem_reg <= rem_new[DVS_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/prma_back.sv -----
`default_nettype none

module prma_back #(
    parameter int CHANNELS   = 4,
    parameter int MAX_WINDOW = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  prma_pkg::cfg_wr_t     cfg,
    input  prma_pkg::queue_stat_t q_stat,
    input  prma_pkg::work_t       head,
    output logic                  pop,
    prma_out_if.source            out_ch
);
    import prma_pkg::*;

    localparam int CIW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int EW     = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH  = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);

    // per-channel state
    logic [WIN_W-1:0]   window_reg  [NUM_REGS];
    logic [TOTAL_W-1:0] total_reg   [CHANNELS];
    logic [SLOT_W-1:0]  slot_reg    [CHANNELS];
    logic               wrapped_reg [CHANNELS];

    // rate rings, all channels in one memory
    logic [RATE_W-1:0]  ring_mem [DEPTH];
    logic [RATE_W-1:0]  rd_data_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    work_t              item_reg;

    logic               out_valid_reg;
    logic [CH_W-1:0]    out_channel_reg;
    logic [RATE_W-1:0]  out_rate_reg;
    logic [RATE_W-1:0]  out_avg_reg;

    logic [WIN_W-1:0]   win_raw;
    logic [EW-1:0]      eff_w;
    logic [CIW-1:0]     ci;
    logic [SLOT_W-1:0]  cur_slot;
    logic [EW-1:0]      slot_inc;
    logic               wrap_now;
    logic [ADDR_W-1:0]  addr;
    logic [RATE_W-1:0]  old_rate;
    logic [TOTAL_W-1:0] total_new;

    logic               div_start;
    logic               div_done;
    logic [TOTAL_W-1:0] quotient;
    logic               load_out;
    logic               cfg_clear;

    // effective window: zero acts as one, clipped to the ring length
    assign win_raw = window_reg[item_reg.channel];
    always_comb
    begin
        if (win_raw == '0)
        begin
            eff_w = EW'(1);
        end
        else if (32'(win_raw) > MAX_WINDOW)
        begin
            eff_w = EW'(MAX_WINDOW);
        end
        else
        begin
            eff_w = EW'(win_raw);
        end
    end

    // slot, ring address and running total update
    assign ci       = CIW'(item_reg.channel);
    assign cur_slot = (EW'(slot_reg[ci]) >= eff_w) ? '0 : slot_reg[ci];
    assign slot_inc = EW'(cur_slot) + EW'(1);
    assign wrap_now = (slot_inc >= eff_w);
    assign addr     = ADDR_W'(ci * MAX_WINDOW) + ADDR_W'(cur_slot);

    // entries not yet written since the last clear read as zero
    assign old_rate  = wrapped_reg[ci] ? rd_data_reg : '0;
    assign total_new = total_reg[ci] - TOTAL_W'(old_rate) + TOTAL_W'(item_reg.rate);

    assign cfg_clear = cfg.we && (32'(cfg.index) < CHANNELS);

    prma_div #(
        .DVS_W (EW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_new),
        .divisor  (eff_w),
        .done     (div_done),
        .quotient (quotient)
    );

    // sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = head.absent ? BK_DONE : BK_READ;
                end
            end
            BK_READ: state_next = BK_CALC;
            BK_CALC: state_next = BK_DIV;
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb
    begin
        pop       = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop = !q_stat.empty;
            BK_READ: ;
            BK_CALC: div_start = 1'b1;
            BK_DIV:  ;
            BK_DONE: load_out = !out_valid_reg || out_ch.ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // current word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= ring_mem[addr];
        if (state_reg == BK_CALC)
        begin
            ring_mem[addr] <= item_reg.rate;
        end
    end

    // window registers and per-channel ring bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                window_reg[i] <= WIN_W'(1);
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                total_reg[i]   <= '0;
                slot_reg[i]    <= '0;
                wrapped_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (state_reg == BK_CALC)
            begin
                total_reg[ci]   <= total_new;
                slot_reg[ci]    <= wrap_now ? '0 : slot_inc[SLOT_W-1:0];
                wrapped_reg[ci] <= wrapped_reg[ci] || wrap_now;
            end
            if (cfg.we)
            begin
                window_reg[cfg.index] <= cfg.data;
            end
            if (cfg_clear)
            begin
                total_reg[CIW'(cfg.index)]   <= '0;
                slot_reg[CIW'(cfg.index)]    <= '0;
                wrapped_reg[CIW'(cfg.index)] <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_channel_reg <= item_reg.channel;
            out_rate_reg    <= item_reg.rate;
            out_avg_reg     <= item_reg.absent ? '0 : quotient[RATE_W-1:0];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.out_channel  = out_channel_reg;
    assign out_ch.period_rate  = out_rate_reg;
    assign out_ch.average_rate = out_avg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pulse_rate_moving_average.sv -----
`default_nettype none

// Channel   Dir  Handshake      Word
// in_ch     in   valid/ready    channel, pulse_count
// out_ch    out  valid/ready    out_channel, period_rate, average_rate
// cfg       in   cfg_we only    cfg_index, cfg_data (window length per channel)
//
// From queue pop to result register a word passes ring read, update, 22
// divider steps, divider finish and result load; no new word is popped until
// that result is loaded. Absent channels skip ring and divider. A two-word
// queue parts front from back, so up to two inputs are taken while the back
// works or the result waits. Reset clears control and per-channel state at
// once; ring entries are tracked per channel by a wrap flag, not cleared.

module pulse_rate_moving_average #(
    parameter int CHANNELS   = 4,
    parameter int MAX_WINDOW = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    prma_in_if.sink                        in_ch,
    prma_out_if.source                     out_ch,
    input  logic                           cfg_we,
    input  logic [prma_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [prma_pkg::WIN_W-1:0]     cfg_data
);
    import prma_pkg::*;

    cfg_wr_t     cfg;
    queue_stat_t q_stat;
    work_t       push_word;
    work_t       head;
    logic        push;
    logic        pop;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    prma_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .q_stat    (q_stat),
        .push      (push),
        .push_word (push_word)
    );

    prma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    prma_back #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

    // queue cannot be full and empty at once
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // an accepted word is in the queue on the next edge
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !q_stat.empty)
        else $error("accepted word missing from queue");

    // results of absent channels carry zero rates
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (32'(out_ch.out_channel) >= CHANNELS))
            |-> (out_ch.period_rate == '0 && out_ch.average_rate == '0))
        else $error("absent channel gave nonzero result");

endmodule

`default_nettype wire

// ----- tb/tb_pulse_rate_moving_average.sv -----
module tb_pulse_rate_moving_average;
    import prma_pkg::*;

    localparam int CHANNELS      = 4;
    localparam int MAX_WINDOW    = 64;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 125;
    localparam int LIMIT_CYCLES  = 200000;

    // window register indexes
    localparam int REG_WINDOW_0 = 0;
    localparam int REG_WINDOW_1 = 1;
    localparam int REG_WINDOW_2 = 2;
    localparam int REG_WINDOW_3 = 3;

    typedef struct {
        logic [CH_W-1:0]    ch;
        logic [COUNT_W-1:0] count;
    } sample_t;

    typedef struct {
        logic [CH_W-1:0]   ch;
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] avg;
    } rate_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [WIN_W-1:0]     cfg_data;

    prma_in_if  in_if ();
    prma_out_if out_if ();

    pulse_rate_moving_average #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [WIN_W-1:0]   win_reg    [NUM_REGS];
    logic [COUNT_W-1:0] last_count [CHANNELS];
    logic [RATE_W-1:0]  rate_ring  [CHANNELS][MAX_WINDOW];
    logic [TOTAL_W-1:0] rate_total [CHANNELS];
    int unsigned        ring_slot  [CHANNELS];

    // stimulus side
    sample_t            sample_queue [$];
    rate_result_t       expected_rates [$];
    logic [COUNT_W-1:0] count_track [CHANNELS];
    sample_t            drive_word;
    sample_t            taken_word;
    rate_result_t       exp_word;
    logic               in_fire = 1'b0;
    logic               no_idle = 1'b0;

    int samples_taken   = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int window_writes   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one sample period: new rate, ring update, running average
    function automatic rate_result_t average_step(input sample_t s);
        rate_result_t r;
        logic [RATE_W-1:0] rate;
        int unsigned w;
        int unsigned slot;
        // with four channels on a 2-bit field every channel is present
        rate = RATE_W'(s.count - last_count[s.ch]);
        last_count[s.ch] = s.count;
        w = 32'(win_reg[s.ch]);
        if (w == 0)
            w = 1;
        if (w > MAX_WINDOW)
            w = MAX_WINDOW;
        slot = ring_slot[s.ch];
        if (slot >= w)
            slot = 0;
        rate_total[s.ch] = rate_total[s.ch] - TOTAL_W'(rate_ring[s.ch][slot]);
        rate_ring[s.ch][slot] = rate;
        rate_total[s.ch] = rate_total[s.ch] + TOTAL_W'(rate);
        slot++;
        if (slot >= w)
            slot = 0;
        ring_slot[s.ch] = slot;
        r.ch   = s.ch;
        r.rate = rate;
        r.avg  = RATE_W'(rate_total[s.ch] / w);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [RATE_W-1:0] want,
                                        input logic [RATE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // next cumulative count: small steps, repeats, near-16-bit steps, 16-bit wraps, random 16-bit steps, jumps
    function automatic logic [COUNT_W-1:0] next_count(input logic [CH_W-1:0] ch);
        int unsigned pick;
        logic [COUNT_W-1:0] delta;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            delta = $urandom_range(0, 20);
        else if (pick < 40)
            delta = 32'h0000_FFFF - $urandom_range(0, 20);
        else if (pick < 50)
            delta = '0;
        else if (pick < 60)
            delta = 32'h0001_0000 + $urandom_range(0, 3);
        else if (pick < 85)
            delta = $urandom_range(0, 65535);
        else
            return $urandom();
        return count_track[ch] + delta;
    endfunction

    function automatic logic [WIN_W-1:0] pick_window();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return WIN_W'($urandom_range(1, 8));
        else if (pick < 50)
            return WIN_W'(MAX_WINDOW);
        else if (pick < 60)
            return '0;
        else if (pick < 70)
            return WIN_W'($urandom_range(MAX_WINDOW + 1, 127));
        else
            return WIN_W'($urandom_range(1, MAX_WINDOW));
    endfunction

    task automatic queue_sample(input logic [CH_W-1:0] ch, input logic [COUNT_W-1:0] count);
        sample_t s;
        s.ch    = ch;
        s.count = count;
        count_track[ch] = count;
        sample_queue.push_back(s);
    endtask

    // write a window register; the channel's ring, total and slot restart
    task automatic write_window(input int idx, input logic [WIN_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_IDX_W'(idx);
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        win_reg[idx] = val;
        if (idx < CHANNELS)
        begin
            for (int k = 0; k < MAX_WINDOW; k++)
                rate_ring[idx][k] = '0;
            rate_total[idx] = '0;
            ring_slot[idx]  = 0;
        end
        window_writes++;
    endtask

    task automatic wait_drained();
        while (sample_queue.size() != 0 || in_if.valid || expected_rates.size() != 0)
            @(posedge clk);
        // let the back end finish before touching registers
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // input driver and output ready
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_if.ready <= no_idle || ($urandom_range(0, 99) >= 10);
            if (!in_if.valid || in_fire)
            begin
                if (sample_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 10))
                begin
                    drive_word = sample_queue.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.channel     <= drive_word.ch;
                    in_if.pulse_count <= drive_word.count;
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // accepted input words feed the predictor
    always @(posedge clk)
    begin
        in_fire = rst_n && in_if.valid && in_if.ready;
        if (in_fire)
        begin
            taken_word.ch    = in_if.channel;
            taken_word.count = in_if.pulse_count;
            expected_rates.push_back(average_step(taken_word));
            samples_taken++;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_rates.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual ch %0d rate %h avg %h",
                         $time, out_if.out_channel, out_if.period_rate, out_if.average_rate);
                mismatches++;
            end
            else
            begin
                exp_word = expected_rates.pop_front();
                check_field("out_channel", RATE_W'(exp_word.ch), RATE_W'(out_if.out_channel));
                check_field("period_rate", exp_word.rate, out_if.period_rate);
                check_field("average_rate", exp_word.avg, out_if.average_rate);
                results_checked++;
            end
        end
    end

    // run limit
    initial
    begin
        #(12 * LIMIT_CYCLES);
        $display("pulse_rate_moving_average regression: fail");
        $finish;
    end

    initial
    begin
        int unsigned focus;
        logic [CH_W-1:0] ch;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_if.valid       = 1'b0;
        in_if.channel     = '0;
        in_if.pulse_count = '0;
        out_if.ready      = 1'b0;
        for (int i = 0; i < NUM_REGS; i++)
            win_reg[i] = 7'd1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            last_count[c]  = '0;
            rate_total[c]  = '0;
            ring_slot[c]   = 0;
            count_track[c] = '0;
            for (int k = 0; k < MAX_WINDOW; k++)
                rate_ring[c][k] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: count wrap, 16-bit truncation, default windows of one
        queue_sample(0, 32'h0000_0000);
        queue_sample(0, 32'hFFFF_FFFF);
        queue_sample(0, 32'h0000_0000);
        queue_sample(1, 32'hFFFF_0000);
        queue_sample(2, 32'h0001_2345);
        queue_sample(3, 32'hAAAA_5555);
        queue_sample(3, 32'h5555_AAAA);
        wait_drained();

        // window zero, full window, and two oversize windows
        write_window(REG_WINDOW_0, 7'd0);
        write_window(REG_WINDOW_1, 7'd64);
        write_window(REG_WINDOW_2, 7'd127);
        write_window(REG_WINDOW_3, 7'd65);
        queue_sample(0, 32'h0000_0005);
        queue_sample(0, 32'h0000_FFFF);
        for (int i = 0; i < 6; i++)
            queue_sample(1, count_track[1] + 32'h0000_FFFF);
        for (int i = 0; i < 3; i++)
        begin
            queue_sample(2, count_track[2] + 32'h0000_FFFE);
            queue_sample(3, count_track[3] + 32'h0000_8001);
        end
        wait_drained();

        // rewrite keeps the last count of the channel
        write_window(REG_WINDOW_1, 7'd2);
        queue_sample(1, count_track[1] + 32'h0000_0123);
        wait_drained();

        // random phases, each rewriting a random choice of windows; phase 3 runs without idles
        for (int p = 0; p < PHASES; p++)
        begin
            for (int r = REG_WINDOW_0; r <= REG_WINDOW_3; r++)
                if ($urandom_range(0, 1) == 1)
                    write_window(r, pick_window());
            no_idle = (p == 3);
            focus = $urandom_range(0, CHANNELS - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // half the phases dwell on one channel so its ring wraps
                if (p % 2 == 1 && $urandom_range(0, 99) < 70)
                    ch = CH_W'(focus);
                else
                    ch = CH_W'($urandom_range(0, CHANNELS - 1));
                queue_sample(ch, next_count(ch));
            end
            wait_drained();
            no_idle = 1'b0;
        end

        $display("covered %0d samples across %0d window register writes",
                 samples_taken, window_writes);
        $display("%0d results checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0 && expected_rates.size() == 0)
            $display("pulse_rate_moving_average regression: pass");
        else
            $display("pulse_rate_moving_average regression: fail");
        $finish;
    end

endmodule

// ----- pulse_rate_moving_average.f -----
rtl/core/prma_pkg.sv
rtl/core/prma_in_if.sv
rtl/core/prma_out_if.sv
rtl/core/prma_front.sv
rtl/core/prma_queue.sv
rtl/core/prma_div.sv
rtl/core/prma_back.sv
rtl/core/pulse_rate_moving_average.sv
tb/tb_pulse_rate_moving_average.sv
